### hdl/lfb_pkg.sv
package lfb_pkg;

    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int BANK_W = 3;

    localparam logic [7:0] LINK_BANK_CMD = 8'h40;
    localparam logic [7:0] LINK_COL_CMD  = 8'h80;

    typedef enum logic [2:0] {
        CMD_SET   = 3'd0,
        CMD_READ  = 3'd1,
        CMD_FILL  = 3'd2,
        CMD_FLUSH = 3'd3,
        CMD_TICK  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_BANK   = 2'd1,
        PH_COLUMN = 2'd2,
        PH_DATA   = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_REJECT,
        ACT_BANK,
        ACT_COLUMN,
        ACT_DATA,
        ACT_SET,
        ACT_READ,
        ACT_FILL,
        ACT_START
    } act_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_en;
        logic sweep_en;
        logic sweep_zero;
        logic finish;
        act_t act;
    } dp_cmd_t;

    typedef struct packed {
        phase_t phase;
        logic   in_range;
        logic   sweep_last;
        logic   out_free;
    } dp_status_t;

endpackage

### hdl/lcd_framebuffer_dirty_rect_render.sv
// Banked monochrome frame store with dirty-rectangle flush to a display link.
// Input channel (in_valid/in_stall) carries one command transaction: cmd, x, y,
// color, fill_byte. Output channel (out_valid/out_stall) returns exactly one
// result transaction per command: pixel_value, link_valid, link_dc, link_byte,
// flush_busy, rejected.
// A command is taken while in_stall is low; its result is loaded into the output
// register from the finish state once that register is free. Fill writes the
// whole store through the single write port, one byte a cycle, before its
// result is loaded.
// Each flush tick yields one link byte; data bytes read the store's registered
// read port in the accept cycle.
// Reset: control state clears at once, then a clearing pass writes zeros to
// every store byte with in_stall high. After reset the whole screen is marked
// dirty.
// Output stall: a finished result waits in the output register; the next
// command is still taken, and its result is held back until the first one is
// taken.
module lcd_framebuffer_dirty_rect_render #(
    parameter int WIDTH  = 84,
    parameter int HEIGHT = 48
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              cmd,
    input  logic [lfb_pkg::X_W-1:0] x,
    input  logic [lfb_pkg::Y_W-1:0] y,
    input  logic                    color,
    input  logic [7:0]              fill_byte,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    pixel_value,
    output logic                    link_valid,
    output logic                    link_dc,
    output logic [7:0]              link_byte,
    output logic                    flush_busy,
    output logic                    rejected
);

    lfb_pkg::dp_cmd_t    ctl;
    lfb_pkg::dp_status_t status;

    lfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status),
        .ctl      (ctl)
    );

    lfb_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .x           (x),
        .y           (y),
        .color       (color),
        .fill_byte   (fill_byte),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_value (pixel_value),
        .link_valid  (link_valid),
        .link_dc     (link_dc),
        .link_byte   (link_byte),
        .flush_busy  (flush_busy),
        .rejected    (rejected)
    );

endmodule

### hdl/lfb_datapath.sv
module lfb_datapath #(
    parameter int WIDTH  = 84,
    parameter int HEIGHT = 48
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lfb_pkg::dp_cmd_t          ctl,
    output lfb_pkg::dp_status_t       status,
    input  logic [lfb_pkg::X_W-1:0]   x,
    input  logic [lfb_pkg::Y_W-1:0]   y,
    input  logic                      color,
    input  logic [7:0]                fill_byte,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic                      pixel_value,
    output logic                      link_valid,
    output logic                      link_dc,
    output logic [7:0]                link_byte,
    output logic                      flush_busy,
    output logic                      rejected
);

    localparam int BANKS      = (HEIGHT + 7) / 8;
    localparam int STORE_SIZE = WIDTH * BANKS;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int COL_W      = $clog2(WIDTH + 1);
    localparam int ROW_W      = $clog2(HEIGHT + 1);

    logic [7:0] frame_mem [STORE_SIZE];

    logic [7:0]                    rd_data_reg;
    logic [ADDR_W-1:0]             sweep_addr_reg, sweep_addr_next;
    logic [ADDR_W-1:0]             addr_reg, addr_next;
    logic [lfb_pkg::X_W-1:0]       x_reg, x_next;
    logic [lfb_pkg::Y_W-1:0]       y_reg, y_next;
    logic                          color_reg, color_next;
    logic [7:0]                    fill_reg, fill_next;

    logic [ROW_W-1:0]              dirty_top_reg, dirty_top_next;
    logic [ROW_W-1:0]              dirty_bottom_reg, dirty_bottom_next;
    logic [COL_W-1:0]              dirty_left_reg, dirty_left_next;
    logic [COL_W-1:0]              dirty_right_reg, dirty_right_next;
    logic [lfb_pkg::BANK_W-1:0]    flush_bank_reg, flush_bank_next;
    logic [COL_W-1:0]              flush_col_reg, flush_col_next;
    lfb_pkg::phase_t               phase_reg, phase_next;

    logic                          out_valid_reg, out_valid_next;
    logic                          pix_reg, pix_next;
    logic                          lv_reg, lv_next;
    logic                          dc_reg, dc_next;
    logic [7:0]                    lb_reg, lb_next;
    logic                          busy_reg, busy_next;
    logic                          rej_reg, rej_next;

    logic [ADDR_W-1:0]             pix_addr;
    logic [ADDR_W-1:0]             flush_addr;
    logic [ADDR_W-1:0]             rd_addr;
    logic                          sweep_last;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_waddr;
    logic [7:0]                    mem_wdata;
    logic [7:0]                    bit_mask;
    logic [7:0]                    set_byte;
    logic [COL_W-1:0]              col_inc;
    logic [ROW_W-1:0]              bottom_m1;
    logic [lfb_pkg::BANK_W-1:0]    last_bank;
    logic [COL_W-1:0]              x_col;
    logic [ROW_W-1:0]              y_row;
    logic [ROW_W-1:0]              y_row_inc;
    logic [COL_W-1:0]              x_col_inc;

    assign pix_addr   = ADDR_W'(y[lfb_pkg::Y_W-1:3]) * ADDR_W'(WIDTH) + ADDR_W'(x);
    assign flush_addr = ADDR_W'(flush_bank_reg) * ADDR_W'(WIDTH) + ADDR_W'(flush_col_reg);
    assign rd_addr    = (phase_reg != lfb_pkg::PH_IDLE) ? flush_addr : pix_addr;
    assign sweep_last = (sweep_addr_reg == ADDR_W'(STORE_SIZE - 1));

    assign bit_mask  = 8'd1 << y_reg[2:0];
    assign set_byte  = color_reg ? (rd_data_reg | bit_mask) : (rd_data_reg & ~bit_mask);
    assign mem_we    = ctl.sweep_en || (ctl.finish && ctl.act == lfb_pkg::ACT_SET);
    assign mem_waddr = ctl.sweep_en ? sweep_addr_reg : addr_reg;
    assign mem_wdata = ctl.sweep_en ? (ctl.sweep_zero ? 8'd0 : fill_reg) : set_byte;

    assign col_inc   = flush_col_reg + COL_W'(1);
    assign bottom_m1 = dirty_bottom_reg - ROW_W'(1);
    assign last_bank = lfb_pkg::BANK_W'(bottom_m1 >> 3);
    assign x_col     = COL_W'(x_reg);
    assign y_row     = ROW_W'(y_reg);
    assign x_col_inc = x_col + COL_W'(1);
    assign y_row_inc = y_row + ROW_W'(1);

    assign status.phase      = phase_reg;
    assign status.in_range   = ({1'b0, x} < 8'(WIDTH)) && ({1'b0, y} < 7'(HEIGHT));
    assign status.sweep_last = sweep_last;
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk) begin
        if (mem_we) begin
            frame_mem[mem_waddr] <= mem_wdata;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_comb begin
        sweep_addr_next = sweep_addr_reg;
        if (ctl.sweep_en) begin
            sweep_addr_next = sweep_last ? '0 : sweep_addr_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        addr_next  = addr_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        color_next = color_reg;
        fill_next  = fill_reg;
        if (ctl.accept) begin
            addr_next  = pix_addr;
            x_next     = x;
            y_next     = y;
            color_next = color;
            fill_next  = fill_byte;
        end
    end

    always_comb begin
        dirty_top_next    = dirty_top_reg;
        dirty_bottom_next = dirty_bottom_reg;
        dirty_left_next   = dirty_left_reg;
        dirty_right_next  = dirty_right_reg;
        flush_bank_next   = flush_bank_reg;
        flush_col_next    = flush_col_reg;
        phase_next        = phase_reg;
        out_valid_next    = out_valid_reg && out_stall;
        pix_next          = pix_reg;
        lv_next           = lv_reg;
        dc_next           = dc_reg;
        lb_next           = lb_reg;
        busy_next         = busy_reg;
        rej_next          = rej_reg;
        if (ctl.finish) begin
            out_valid_next = 1'b1;
            pix_next       = 1'b0;
            lv_next        = 1'b0;
            dc_next        = 1'b0;
            lb_next        = 8'd0;
            rej_next       = 1'b0;
            unique case (ctl.act)
                lfb_pkg::ACT_NONE: begin
                end
                lfb_pkg::ACT_REJECT: begin
                    rej_next = 1'b1;
                end
                lfb_pkg::ACT_BANK: begin
                    lv_next    = 1'b1;
                    lb_next    = lfb_pkg::LINK_BANK_CMD | 8'(flush_bank_reg);
                    phase_next = lfb_pkg::PH_COLUMN;
                end
                lfb_pkg::ACT_COLUMN: begin
                    lv_next        = 1'b1;
                    lb_next        = lfb_pkg::LINK_COL_CMD | {1'b0, 7'(dirty_left_reg)};
                    flush_col_next = dirty_left_reg;
                    phase_next     = lfb_pkg::PH_DATA;
                end
                lfb_pkg::ACT_DATA: begin
                    lv_next        = 1'b1;
                    dc_next        = 1'b1;
                    lb_next        = rd_data_reg;
                    flush_col_next = col_inc;
                    if (col_inc >= dirty_right_reg) begin
                        if (flush_bank_reg >= last_bank) begin
                            dirty_top_next    = ROW_W'(HEIGHT);
                            dirty_left_next   = COL_W'(WIDTH);
                            dirty_bottom_next = '0;
                            dirty_right_next  = '0;
                            phase_next        = lfb_pkg::PH_IDLE;
                        end else begin
                            flush_bank_next = flush_bank_reg + lfb_pkg::BANK_W'(1);
                            phase_next      = lfb_pkg::PH_BANK;
                        end
                    end
                end
                lfb_pkg::ACT_SET: begin
                    if (y_row < dirty_top_reg) dirty_top_next = y_row;
                    if (x_col < dirty_left_reg) dirty_left_next = x_col;
                    if (y_row_inc > dirty_bottom_reg) dirty_bottom_next = y_row_inc;
                    if (x_col_inc > dirty_right_reg) dirty_right_next = x_col_inc;
                end
                lfb_pkg::ACT_READ: begin
                    pix_next = rd_data_reg[y_reg[2:0]];
                end
                lfb_pkg::ACT_FILL: begin
                    dirty_top_next  = '0;
                    dirty_left_next = '0;
                    if (ROW_W'(HEIGHT) > dirty_bottom_reg) dirty_bottom_next = ROW_W'(HEIGHT);
                    if (COL_W'(WIDTH) > dirty_right_reg) dirty_right_next = COL_W'(WIDTH);
                end
                lfb_pkg::ACT_START: begin
                    if (dirty_top_reg < dirty_bottom_reg && dirty_left_reg < dirty_right_reg) begin
                        flush_bank_next = lfb_pkg::BANK_W'(dirty_top_reg >> 3);
                        flush_col_next  = dirty_left_reg;
                        phase_next      = lfb_pkg::PH_BANK;
                    end
                end
                default: begin
                end
            endcase
            busy_next = (phase_next != lfb_pkg::PH_IDLE);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sweep_addr_reg   <= '0;
            dirty_top_reg    <= '0;
            dirty_left_reg   <= '0;
            dirty_bottom_reg <= ROW_W'(HEIGHT);
            dirty_right_reg  <= COL_W'(WIDTH);
            flush_bank_reg   <= '0;
            flush_col_reg    <= '0;
            phase_reg        <= lfb_pkg::PH_IDLE;
            out_valid_reg    <= 1'b0;
        end else begin
            sweep_addr_reg   <= sweep_addr_next;
            dirty_top_reg    <= dirty_top_next;
            dirty_left_reg   <= dirty_left_next;
            dirty_bottom_reg <= dirty_bottom_next;
            dirty_right_reg  <= dirty_right_next;
            flush_bank_reg   <= flush_bank_next;
            flush_col_reg    <= flush_col_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        addr_reg  <= addr_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        color_reg <= color_next;
        fill_reg  <= fill_next;
        pix_reg   <= pix_next;
        lv_reg    <= lv_next;
        dc_reg    <= dc_next;
        lb_reg    <= lb_next;
        busy_reg  <= busy_next;
        rej_reg   <= rej_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pix_reg;
    assign link_valid  = lv_reg;
    assign link_dc     = dc_reg;
    assign link_byte   = lb_reg;
    assign flush_busy  = busy_reg;
    assign rejected    = rej_reg;

`ifndef SYNTHESIS
    a_flush_rect_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != lfb_pkg::PH_IDLE |->
            (dirty_top_reg < dirty_bottom_reg && dirty_left_reg < dirty_right_reg))
        else $error("flush running on an empty rectangle");

    a_data_col_in_rect: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == lfb_pkg::PH_DATA |-> flush_col_reg < dirty_right_reg)
        else $error("flush column past right edge");

    a_link_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(rej_reg && lv_reg))
        else $error("link byte sent on a rejected transaction");
`endif

endmodule

### hdl/lfb_ctrl.sv
module lfb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          cmd,
    input  lfb_pkg::dp_status_t status,
    output lfb_pkg::dp_cmd_t    ctl
);

    lfb_pkg::state_t state_reg, state_next;
    lfb_pkg::act_t   act_reg, act_next;
    lfb_pkg::act_t   act_dec;
    logic            accept;

    assign accept = (state_reg == lfb_pkg::ST_IDLE) && in_valid;

    always_comb begin
        act_dec = lfb_pkg::ACT_NONE;
        if (status.phase != lfb_pkg::PH_IDLE) begin
            if (cmd != lfb_pkg::CMD_TICK) begin
                act_dec = lfb_pkg::ACT_REJECT;
            end else begin
                unique case (status.phase)
                    lfb_pkg::PH_BANK:   act_dec = lfb_pkg::ACT_BANK;
                    lfb_pkg::PH_COLUMN: act_dec = lfb_pkg::ACT_COLUMN;
                    lfb_pkg::PH_DATA:   act_dec = lfb_pkg::ACT_DATA;
                    default:            act_dec = lfb_pkg::ACT_NONE;
                endcase
            end
        end else begin
            unique case (cmd)
                lfb_pkg::CMD_SET:
                    act_dec = status.in_range ? lfb_pkg::ACT_SET : lfb_pkg::ACT_NONE;
                lfb_pkg::CMD_READ:
                    act_dec = status.in_range ? lfb_pkg::ACT_READ : lfb_pkg::ACT_NONE;
                lfb_pkg::CMD_FILL:  act_dec = lfb_pkg::ACT_FILL;
                lfb_pkg::CMD_FLUSH: act_dec = lfb_pkg::ACT_START;
                default:            act_dec = lfb_pkg::ACT_NONE;
            endcase
        end
    end

    assign act_next = accept ? act_dec : act_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lfb_pkg::ST_CLEAR: begin
                if (status.sweep_last) state_next = lfb_pkg::ST_IDLE;
            end
            lfb_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (act_dec == lfb_pkg::ACT_FILL) ?
                                 lfb_pkg::ST_FILL : lfb_pkg::ST_FINISH;
                end
            end
            lfb_pkg::ST_FILL: begin
                if (status.sweep_last) state_next = lfb_pkg::ST_FINISH;
            end
            lfb_pkg::ST_FINISH: begin
                if (status.out_free) state_next = lfb_pkg::ST_IDLE;
            end
            default: state_next = lfb_pkg::ST_CLEAR;
        endcase
    end

    always_comb begin
        in_stall       = (state_reg != lfb_pkg::ST_IDLE);
        ctl.accept     = accept;
        ctl.rd_en      = accept && (act_dec == lfb_pkg::ACT_SET ||
                                    act_dec == lfb_pkg::ACT_READ ||
                                    act_dec == lfb_pkg::ACT_DATA);
        ctl.sweep_en   = (state_reg == lfb_pkg::ST_CLEAR) || (state_reg == lfb_pkg::ST_FILL);
        ctl.sweep_zero = (state_reg == lfb_pkg::ST_CLEAR);
        ctl.finish     = (state_reg == lfb_pkg::ST_FINISH) && status.out_free;
        ctl.act        = act_reg;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= lfb_pkg::ST_CLEAR;
            act_reg   <= lfb_pkg::ACT_NONE;
        end else begin
            state_reg <= state_next;
            act_reg   <= act_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != lfb_pkg::ST_IDLE)
        else $error("accepted transaction did not start work");

    a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.finish |=> state_reg == lfb_pkg::ST_IDLE)
        else $error("finish did not return to idle");

    a_sweep_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.sweep_en |-> !ctl.rd_en && !ctl.finish)
        else $error("store access during sweep");
`endif

endmodule
